// File: src/rfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared types and constants of the reference-counted frame allocator.
// ----------------------------------------------------------------------------
package rfa_pkg;

    localparam int DEFAULT_NUM_FRAMES = 1024;
    localparam int FRAME_W = 20;
    localparam int CNT_W   = 15;
    localparam int ENTRY_W = 16;

    localparam logic [FRAME_W-1:0] BASE_RESET = 20'd256;
    // A free entry holds the next free index, or END_MARK for the list tail.
    localparam logic [ENTRY_W-1:0] END_MARK  = 16'h8000;
    // An allocated entry holds its count negated: ENTRY_ONE is count one.
    localparam logic [ENTRY_W-1:0] ENTRY_ONE = 16'hFFFF;
    localparam logic [ENTRY_W-1:0] ENTRY_MAX = 16'h8001;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_MARK  = 2'd1,
        CMD_INC   = 2'd2,
        CMD_DEC   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NONE_FREE = 3'd1,
        ST_OUT_RGN   = 3'd2,
        ST_NOT_FREE  = 3'd3,
        ST_NOT_ALLOC = 3'd4,
        ST_SATURATED = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_ALLOC,
        S_ENTRY,
        S_WALK,
        S_MARK,
        S_OUT
    } t_state;

    typedef struct packed {
        t_cmd               cmd;
        logic [FRAME_W-1:0] frame;
    } t_in_item;

    typedef struct packed {
        logic [FRAME_W-1:0] alloc_frame;
        logic [CNT_W-1:0]   ref_count;
        t_status            status;
    } t_out_item;

endpackage

// File: src/rfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/refcounted_frame_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_frame_allocator_core
// Free-list frame allocator with per-frame reference counts.
// ----------------------------------------------------------------------------
// After reset the block chains the frame table into one free list and accepts
// no command meanwhile; configuration writes are taken at any time. Commands are
// handled one at a time. Allocate passes through decode, a read of the list head
// and the result state; increment, decrement and a mark-used that is refused or
// that hits the list head read the frame's entry instead. A command outside the
// region and an allocate with no free frame go from decode straight to the
// result state. Mark-used on a frame that is not the list head walks the free
// list through the single table read port, one link per cycle, and on finding
// the predecessor relinks it and marks the frame. A result that cannot leave
// because the previous one still waits holds the block until the output register
// frees. The result sits in an output register, so a new command is taken while
// the previous result still waits.
module refcounted_frame_allocator_core
    import rfa_pkg::*;
#(
    parameter int NUM_FRAMES = DEFAULT_NUM_FRAMES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [FRAME_W-1:0] i_cfg_data
);

    localparam int IDX_W  = $clog2(NUM_FRAMES);
    localparam int STEP_W = $clog2(NUM_FRAMES + 1);
    localparam logic [ENTRY_W-1:0] NUM_ENTRY  = ENTRY_W'(NUM_FRAMES);
    localparam logic [FRAME_W-1:0] NUM_FRAME  = FRAME_W'(NUM_FRAMES);
    localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(NUM_FRAMES - 1);
    localparam logic [STEP_W-1:0]  STEP_LIMIT = STEP_W'(NUM_FRAMES);

    t_state               r_state, n_state;
    logic [FRAME_W-1:0]   r_base;
    t_cmd                 r_cmd, n_cmd;
    logic [FRAME_W-1:0]   r_frame, n_frame;
    logic [IDX_W-1:0]     r_off, n_off;
    logic [IDX_W-1:0]     r_head, n_head;
    logic                 r_empty, n_empty;
    logic [ENTRY_W-1:0]   r_entry, n_entry;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [STEP_W-1:0]    r_steps, n_steps;
    t_out_item            r_res, n_res;
    t_out_item            r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    logic                 wr_en, rd_en;
    logic [IDX_W-1:0]     wr_addr, rd_addr;
    logic [ENTRY_W-1:0]   wr_data, rd_data;

    logic [FRAME_W:0]     diff;
    logic                 out_rgn;
    logic                 rd_alloc;
    logic [ENTRY_W-1:0]   adj_entry;
    logic [ENTRY_W-1:0]   neg_rd, neg_adj;
    logic [ENTRY_W-1:0]   head_ext, off_ext, idx_ext;
    logic [STEP_W-1:0]    steps_inc;

    rfa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_FRAMES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Region check: a borrow means the frame lies below the base.
    assign diff    = {1'b0, r_frame} - {1'b0, r_base};
    assign out_rgn = diff[FRAME_W] || (diff[FRAME_W-1:0] >= NUM_FRAME);

    assign rd_alloc  = (rd_data > END_MARK);
    // Shared entry adjuster: increment lowers the negated count, decrement raises it.
    assign adj_entry = rd_data + ((r_cmd == CMD_INC) ? 16'hFFFF : 16'h0001);
    assign neg_rd    = ~rd_data + 16'd1;
    assign neg_adj   = ~adj_entry + 16'd1;

    assign head_ext  = ENTRY_W'(r_head);
    assign off_ext   = ENTRY_W'(r_off);
    assign idx_ext   = ENTRY_W'(r_idx);
    assign steps_inc = r_steps + STEP_W'(1);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_frame     = r_frame;
        n_off       = r_off;
        n_head      = r_head;
        n_empty     = r_empty;
        n_entry     = r_entry;
        n_idx       = r_idx;
        n_steps     = r_steps;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        wr_en       = 1'b0;
        wr_addr     = r_off;
        wr_data     = ENTRY_ONE;
        rd_en       = 1'b0;
        rd_addr     = r_off;

        case (r_state)
            S_INIT: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = (r_idx == LAST_IDX) ? END_MARK : idx_ext + 16'd1;
                n_idx   = r_idx + IDX_W'(1);
                if (r_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_data.cmd;
                    n_frame = i_in_data.frame;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res.alloc_frame = r_frame;
                n_res.ref_count   = '0;
                n_res.status      = ST_OK;
                n_off             = diff[IDX_W-1:0];
                if (r_cmd == CMD_ALLOC) begin
                    n_res.alloc_frame = '0;
                    if (r_empty) begin
                        n_res.status = ST_NONE_FREE;
                        n_state      = S_OUT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_head;
                        n_state = S_ALLOC;
                    end
                end else if (out_rgn) begin
                    n_res.status = ST_OUT_RGN;
                    n_state      = S_OUT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = diff[IDX_W-1:0];
                    n_state = S_ENTRY;
                end
            end
            S_ALLOC: begin
                if (rd_data >= NUM_ENTRY) begin
                    n_empty = 1'b1;
                end else begin
                    n_head = rd_data[IDX_W-1:0];
                end
                wr_en             = 1'b1;
                wr_addr           = r_head;
                wr_data           = ENTRY_ONE;
                n_res.alloc_frame = r_base + FRAME_W'(r_head);
                n_res.ref_count   = CNT_W'(1);
                n_state           = S_OUT;
            end
            S_ENTRY: begin
                n_entry = rd_data;
                n_state = S_OUT;
                if (r_cmd == CMD_MARK) begin
                    if (rd_alloc || r_empty) begin
                        n_res.status    = ST_NOT_FREE;
                        n_res.ref_count = rd_alloc ? neg_rd[CNT_W-1:0] : '0;
                    end else if (r_head == r_off) begin
                        if (rd_data >= NUM_ENTRY) begin
                            n_empty = 1'b1;
                        end else begin
                            n_head = rd_data[IDX_W-1:0];
                        end
                        wr_en           = 1'b1;
                        wr_data         = ENTRY_ONE;
                        n_res.ref_count = CNT_W'(1);
                    end else begin
                        // Walk from the head to find the predecessor of the frame.
                        n_idx   = r_head;
                        n_steps = '0;
                        rd_en   = 1'b1;
                        rd_addr = r_head;
                        n_state = S_WALK;
                    end
                end else if (!rd_alloc) begin
                    n_res.status = ST_NOT_ALLOC;
                end else if (r_cmd == CMD_INC) begin
                    if (rd_data == ENTRY_MAX) begin
                        n_res.status    = ST_SATURATED;
                        n_res.ref_count = '1;
                    end else begin
                        wr_en           = 1'b1;
                        wr_data         = adj_entry;
                        n_res.ref_count = neg_adj[CNT_W-1:0];
                    end
                end else begin
                    wr_en = 1'b1;
                    if (rd_data == ENTRY_ONE) begin
                        // Count reaches zero: push the frame onto the free list.
                        wr_data         = r_empty ? END_MARK : head_ext;
                        n_head          = r_off;
                        n_empty         = 1'b0;
                        n_res.ref_count = '0;
                    end else begin
                        wr_data         = adj_entry;
                        n_res.ref_count = neg_adj[CNT_W-1:0];
                    end
                end
            end
            S_WALK: begin
                if (rd_data == off_ext) begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx;
                    wr_data = r_entry;
                    n_state = S_MARK;
                end else if (rd_data >= NUM_ENTRY || steps_inc == STEP_LIMIT) begin
                    n_res.status = ST_NOT_FREE;
                    n_state      = S_OUT;
                end else begin
                    n_idx   = rd_data[IDX_W-1:0];
                    n_steps = steps_inc;
                    rd_en   = 1'b1;
                    rd_addr = rd_data[IDX_W-1:0];
                end
            end
            S_MARK: begin
                wr_en           = 1'b1;
                wr_data         = ENTRY_ONE;
                n_res.ref_count = CNT_W'(1);
                n_state         = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_base      <= BASE_RESET;
            r_head      <= '0;
            r_empty     <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_empty     <= n_empty;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_frame <= n_frame;
        r_off   <= n_off;
        r_entry <= n_entry;
        r_steps <= n_steps;
        r_res   <= n_res;
        r_out   <= n_out;
    end

endmodule

// File: tb/refcounted_frame_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_frame_allocator_core_tb
// Self-checking testbench for the reference-counted frame allocator. A short
// table of directed commands is followed by a short increment ramp on one frame
// and by random traffic under several region bases, one of which drains the
// free list completely. Every result is compared field by field with the fixed
// value of its directed row or else with the testbench's model of the frame table.
// ----------------------------------------------------------------------------
module refcounted_frame_allocator_core_tb;
    import rfa_pkg::*;

    localparam int NUM_FRAMES     = DEFAULT_NUM_FRAMES;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int RAMP_LEN       = 40;

    typedef struct {
        t_cmd               cmd;
        logic [FRAME_W-1:0] frame;
        bit                 fixed;
        logic [FRAME_W-1:0] e_frame;
        logic [CNT_W-1:0]   e_count;
        t_status            e_status;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in_item           i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out_item          o_out_data;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [FRAME_W-1:0] i_cfg_data;

    // Model of the allocator state.
    logic [ENTRY_W-1:0] frame_links [NUM_FRAMES];
    int unsigned        pool_head;
    bit                 pool_empty;
    logic [FRAME_W-1:0] rgn_base;

    t_out_item pending_replies[$];
    t_dir_row  directed_rows[$];

    bit idle_on     = 1'b1;
    int rx_hold_req = 0;
    int mismatches  = 0;
    int n_bases     = 1;
    int cmd_tally    [4];
    int status_tally [8];

    refcounted_frame_allocator_core #(
        .NUM_FRAMES(NUM_FRAMES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic logic [CNT_W-1:0] held_count(input logic [ENTRY_W-1:0] e);
        logic [ENTRY_W-1:0] neg;
        neg = 16'd0 - e;
        if (e > END_MARK) begin
            return neg[CNT_W-1:0];
        end
        return '0;
    endfunction

    // Applies one command to the model and returns the result it should give.
    function automatic t_out_item alloc_outcome(input t_in_item it);
        t_out_item          r;
        logic [ENTRY_W-1:0] e;
        logic [ENTRY_W-1:0] nxt;
        logic [FRAME_W-1:0] off;
        int unsigned        idx;
        int unsigned        steps;
        bit                 found;
        bit                 walking;
        r.alloc_frame = it.frame;
        r.ref_count   = '0;
        r.status      = ST_OK;
        off = it.frame - rgn_base;
        if (it.cmd == CMD_ALLOC) begin
            r.alloc_frame = '0;
            if (pool_empty || pool_head >= NUM_FRAMES) begin
                r.status = ST_NONE_FREE;
            end else begin
                idx = pool_head;
                nxt = frame_links[idx];
                if (nxt >= NUM_FRAMES) begin
                    pool_empty = 1'b1;
                end else begin
                    pool_head = nxt;
                end
                frame_links[idx] = ENTRY_ONE;
                r.alloc_frame = rgn_base + 20'(idx);
                r.ref_count   = 15'd1;
            end
        end else if (it.frame < rgn_base || off >= NUM_FRAMES) begin
            r.status = ST_OUT_RGN;
        end else begin
            e = frame_links[off];
            if (it.cmd == CMD_MARK) begin
                if (e > END_MARK || pool_empty) begin
                    r.status    = ST_NOT_FREE;
                    r.ref_count = held_count(e);
                end else if (pool_head == off) begin
                    if (e >= NUM_FRAMES) begin
                        pool_empty = 1'b1;
                    end else begin
                        pool_head = e;
                    end
                    frame_links[off] = ENTRY_ONE;
                    r.ref_count = 15'd1;
                end else begin
                    // Walk the free list to find the link that points at the frame.
                    idx     = pool_head;
                    steps   = 0;
                    found   = 1'b0;
                    walking = 1'b1;
                    while (walking && steps < NUM_FRAMES && idx < NUM_FRAMES) begin
                        nxt = frame_links[idx];
                        if (nxt == off) begin
                            found   = 1'b1;
                            walking = 1'b0;
                        end else if (nxt >= NUM_FRAMES) begin
                            walking = 1'b0;
                        end else begin
                            idx = nxt;
                        end
                        steps++;
                    end
                    if (found) begin
                        frame_links[idx] = e;
                        frame_links[off] = ENTRY_ONE;
                        r.ref_count = 15'd1;
                    end else begin
                        r.status = ST_NOT_FREE;
                    end
                end
            end else if (!(e > END_MARK)) begin
                r.status = ST_NOT_ALLOC;
            end else if (it.cmd == CMD_INC) begin
                if (e == ENTRY_MAX) begin
                    r.status    = ST_SATURATED;
                    r.ref_count = '1;
                end else begin
                    frame_links[off] = e - 16'd1;
                    r.ref_count = held_count(e - 16'd1);
                end
            end else begin
                if (e == ENTRY_ONE) begin
                    // Count reaches zero: the frame goes back to the head of the list.
                    frame_links[off] = pool_empty ? END_MARK : 16'(pool_head);
                    pool_head  = off;
                    pool_empty = 1'b0;
                end else begin
                    frame_links[off] = e + 16'd1;
                    r.ref_count = held_count(e + 16'd1);
                end
            end
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic issue_cmd(input t_cmd cmd, input logic [FRAME_W-1:0] frame,
                             input bit fixed, input t_out_item fixed_res);
        t_in_item  item;
        t_out_item predicted;
        int        gap;
        item.cmd   = cmd;
        item.frame = frame;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = alloc_outcome(item);
        pending_replies.push_back(fixed ? fixed_res : predicted);
        cmd_tally[cmd]++;
    endtask

    task automatic wait_replies_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
    endtask

    task automatic write_base(input logic [FRAME_W-1:0] value);
        wait_replies_drained();
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        rgn_base = value;
        n_bases++;
    endtask

    // Random commands; frames mostly fall in a small working set near the base.
    task automatic send_mix(input int count, input int pct_alloc);
        t_cmd               cmd;
        logic [FRAME_W-1:0] frame;
        int                 r;
        int                 s;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            s = $urandom_range(0, 9);
            if (r < pct_alloc) begin
                cmd = CMD_ALLOC;
            end else if (s < 2) begin
                cmd = CMD_MARK;
            end else if (s < 5) begin
                cmd = CMD_INC;
            end else begin
                cmd = CMD_DEC;
            end
            r = $urandom_range(0, 99);
            if (r < 8) begin
                frame = 20'($urandom());
            end else if (r < 70) begin
                frame = rgn_base + 20'($urandom_range(0, 47));
            end else begin
                frame = rgn_base + 20'($urandom_range(0, NUM_FRAMES - 1));
            end
            issue_cmd(cmd, frame, 1'b0, '0);
        end
    endtask

    // Result side: checks each transaction and drives ready with random stalls.
    initial begin
        t_out_item want;
        int        stall_left;
        int        hold_left;
        logic      ready_next;
        stall_left = 0;
        hold_left  = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                status_tally[o_out_data.status]++;
                if (pending_replies.size() == 0) begin
                    flag_mismatch($sformatf("result %h with no command outstanding",
                                            o_out_data));
                end else begin
                    want = pending_replies.pop_front();
                    if (o_out_data.alloc_frame !== want.alloc_frame) begin
                        flag_mismatch($sformatf("alloc_frame %h, expected %h",
                                                o_out_data.alloc_frame, want.alloc_frame));
                    end
                    if (o_out_data.ref_count !== want.ref_count) begin
                        flag_mismatch($sformatf("ref_count %0d, expected %0d",
                                                o_out_data.ref_count, want.ref_count));
                    end
                    if (o_out_data.status !== want.status) begin
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                o_out_data.status, want.status));
                    end
                end
            end
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            i_out_ready <= ready_next;
        end
    end

    // Ends the run if no transaction of any kind completes for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog expired with %0d results outstanding", pending_replies.size());
        $display("FAIL refcounted_frame_allocator_core");
        $finish;
    end

    initial begin
        t_dir_row  row;
        t_out_item fixed_res;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        for (int k = 0; k < NUM_FRAMES; k++) begin
            frame_links[k] = 16'(k + 1);
        end
        frame_links[NUM_FRAMES-1] = END_MARK;
        pool_head  = 0;
        pool_empty = 1'b0;
        rgn_base   = BASE_RESET;

        directed_rows.push_back('{CMD_ALLOC, 20'h00000, 1'b1, 20'd256, 15'd1, ST_OK});
        directed_rows.push_back('{CMD_ALLOC, 20'hFFFFF, 1'b1, 20'd257, 15'd1, ST_OK});
        directed_rows.push_back('{CMD_INC,   20'd256,   1'b0, 20'd0,   15'd0, ST_OK});
        directed_rows.push_back('{CMD_INC,   20'd257,   1'b0, 20'd0,   15'd0, ST_OK});
        directed_rows.push_back('{CMD_DEC,   20'd256,   1'b0, 20'd0,   15'd0, ST_OK});
        directed_rows.push_back('{CMD_DEC,   20'd256,   1'b0, 20'd0,   15'd0, ST_OK});
        directed_rows.push_back('{CMD_DEC,   20'd256,   1'b1, 20'd256, 15'd0, ST_NOT_ALLOC});
        directed_rows.push_back('{CMD_INC,   20'd300,   1'b1, 20'd300, 15'd0, ST_NOT_ALLOC});
        directed_rows.push_back('{CMD_MARK,  20'd256,   1'b0, 20'd0,   15'd0, ST_OK});
        directed_rows.push_back('{CMD_MARK,  20'd1279,  1'b0, 20'd0,   15'd0, ST_OK});
        directed_rows.push_back('{CMD_MARK,  20'd257,   1'b0, 20'd0,   15'd0, ST_OK});
        directed_rows.push_back('{CMD_MARK,  20'd700,   1'b0, 20'd0,   15'd0, ST_OK});
        directed_rows.push_back('{CMD_MARK,  20'd1279,  1'b0, 20'd0,   15'd0, ST_OK});
        directed_rows.push_back('{CMD_INC,   20'h00000, 1'b1, 20'h00000, 15'd0, ST_OUT_RGN});
        directed_rows.push_back('{CMD_DEC,   20'hFFFFF, 1'b1, 20'hFFFFF, 15'd0, ST_OUT_RGN});
        directed_rows.push_back('{CMD_MARK,  20'd255,   1'b1, 20'd255, 15'd0, ST_OUT_RGN});
        directed_rows.push_back('{CMD_INC,   20'd1280,  1'b1, 20'd1280, 15'd0, ST_OUT_RGN});
        directed_rows.push_back('{CMD_DEC,   20'd1279,  1'b0, 20'd0,   15'd0, ST_OK});
        directed_rows.push_back('{CMD_ALLOC, 20'd12345, 1'b0, 20'd0,   15'd0, ST_OK});
        directed_rows.push_back('{CMD_MARK,  20'd258,   1'b0, 20'd0,   15'd0, ST_OK});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            fixed_res.alloc_frame = row.e_frame;
            fixed_res.ref_count   = row.e_count;
            fixed_res.status      = row.e_status;
            issue_cmd(row.cmd, row.frame, row.fixed, fixed_res);
        end

        // Hold the result side off so the block fills up and stalls its input.
        rx_hold_req = 400;
        send_mix(30, 30);
        wait_replies_drained();

        // Ramp one frame's count up by a few dozen, then step it down and up.
        idle_on = 1'b0;
        if (frame_links[1] <= END_MARK) begin
            issue_cmd(CMD_MARK, rgn_base + 20'd1, 1'b0, '0);
        end
        repeat (RAMP_LEN) issue_cmd(CMD_INC, rgn_base + 20'd1, 1'b0, '0);
        issue_cmd(CMD_DEC, rgn_base + 20'd1, 1'b0, '0);
        issue_cmd(CMD_INC, rgn_base + 20'd1, 1'b0, '0);
        idle_on = 1'b1;

        send_mix(40, 30);

        write_base(20'h00000);
        send_mix(20, 30);
        // Drain the free list, then try to take and mark frames with none left.
        while (!pool_empty) begin
            issue_cmd(CMD_ALLOC, 20'($urandom()), 1'b0, '0);
        end
        fixed_res.alloc_frame = '0;
        fixed_res.ref_count   = '0;
        fixed_res.status      = ST_NONE_FREE;
        repeat (3) issue_cmd(CMD_ALLOC, 20'($urandom()), 1'b1, fixed_res);
        repeat (4) issue_cmd(CMD_MARK, 20'($urandom_range(0, NUM_FRAMES - 1)), 1'b0, '0);
        send_mix(40, 3);

        write_base(20'hFFFFF);
        send_mix(20, 30);

        write_base(20'(20'hFFFFF - NUM_FRAMES + 1));
        send_mix(20, 30);

        write_base(20'($urandom()));
        send_mix(20, 30);

        // Closing stretch at full rate on both sides.
        write_base(BASE_RESET);
        idle_on = 1'b0;
        send_mix(60, 30);

        wait_replies_drained();
        repeat (64) @(posedge i_clk);

        $display("Covered %0d commands (alloc %0d, mark %0d, inc %0d, dec %0d) over %0d bases.",
                 cmd_tally.sum(),
                 cmd_tally[CMD_ALLOC], cmd_tally[CMD_MARK], cmd_tally[CMD_INC],
                 cmd_tally[CMD_DEC], n_bases);
        $display("Statuses seen: ok %0d, none free %0d, out of region %0d, %s %0d, %s %0d, %s %0d.",
                 status_tally[ST_OK], status_tally[ST_NONE_FREE], status_tally[ST_OUT_RGN],
                 "not free", status_tally[ST_NOT_FREE], "not allocated",
                 status_tally[ST_NOT_ALLOC], "saturated", status_tally[ST_SATURATED]);
        if (mismatches == 0) begin
            $display("PASS refcounted_frame_allocator_core");
        end else begin
            $display("FAIL refcounted_frame_allocator_core");
        end
        $finish;
    end

endmodule
